### hw/rtl/irpfd_pkg.sv
package irpfd_pkg;

    localparam int TICK_W  = 6;
    localparam int COUNT_W = 5;
    localparam int FRAME_W = 17;
    localparam int BYTE_W  = 8;
    localparam int SYM_W   = 3;
    localparam int PHASE_W = 2;

    localparam logic [COUNT_W-1:0] FRAME_BITS = COUNT_W'(FRAME_W);

    // Interval windows, inclusive, in ticks
    localparam logic [TICK_W-1:0] ZERO_LO  = 6'd4;
    localparam logic [TICK_W-1:0] ZERO_HI  = 6'd6;
    localparam logic [TICK_W-1:0] SAME_LO  = 6'd9;
    localparam logic [TICK_W-1:0] SAME_HI  = 6'd11;
    localparam logic [TICK_W-1:0] ONE_LO   = 6'd14;
    localparam logic [TICK_W-1:0] ONE_HI   = 6'd16;
    localparam logic [TICK_W-1:0] STOP_LO  = 6'd19;
    localparam logic [TICK_W-1:0] STOP_HI  = 6'd21;
    localparam logic [TICK_W-1:0] START_LO = 6'd24;
    localparam logic [TICK_W-1:0] START_HI = 6'd26;

    // Symbol codes
    typedef logic [SYM_W-1:0] t_sym;
    localparam t_sym CODE_BAD   = 3'd0;
    localparam t_sym CODE_ZERO  = 3'd1;
    localparam t_sym CODE_SAME  = 3'd2;
    localparam t_sym CODE_ONE   = 3'd3;
    localparam t_sym CODE_STOP  = 3'd4;
    localparam t_sym CODE_START = 3'd5;

    // Decoder phases
    localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
    localparam logic [PHASE_W-1:0] PH_DATA = 2'd1;
    localparam logic [PHASE_W-1:0] PH_STOP = 2'd2;

    // Held symbol handed from the input stage to the frame logic
    typedef struct packed {
        logic item_valid;
        t_sym sym;
    } t_sym_item;

endpackage

### hw/rtl/ir_pulse_frame_decoder.sv
// Pulse-distance IR frame decoder.
// Input channel (i_valid / o_stall / i_pulse_ticks): one item is one measured
// interval length in ticks; it is taken at a rising edge where i_valid is high
// and o_stall is low. Each interval is classified as zero, same-as-previous,
// one, stop, start or invalid.
// Output channel (o_valid / i_stall / o_link_flag, o_device_address,
// o_command_code): one item per completed frame (start, 17 data bits, stop).
// An accepted stop interval passes the input register, then one pass of decode
// logic into the result register, from which the receiver can take it.
// Throughput: one interval per cycle while o_stall is low; the single-pass
// decode sets this figure.
// When the receiver stalls, the finished result holds in the result register
// while intervals that give no result keep flowing; only a second completed
// frame waits in the input register, and o_stall then rises.
// Reset (i_rst_n low, synchronous): both registers empty, decoder idle and
// waiting for a start interval.
module ir_pulse_frame_decoder
    import irpfd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [TICK_W-1:0] i_pulse_ticks,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_link_flag,
    output logic [BYTE_W-1:0] o_device_address,
    output logic [BYTE_W-1:0] o_command_code
);

    logic              r_in_valid;
    logic [TICK_W-1:0] r_in_ticks;
    logic              advance;
    logic              accept;
    t_sym              sym;
    t_sym_item         item;

    // stall only while a held item cannot move on
    assign o_stall = r_in_valid && !advance;
    assign accept  = i_valid && !o_stall;

    // input register: fill on accept, drain when the held item advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_ticks <= i_pulse_ticks;
        end
    end

    irpfd_classify u_classify (
        .i_ticks (r_in_ticks),
        .o_sym   (sym)
    );

    assign item.item_valid = r_in_valid;
    assign item.sym        = sym;

    // frame state and result register
    irpfd_frame u_frame (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item           (item),
        .i_stall          (i_stall),
        .o_advance        (advance),
        .o_valid          (o_valid),
        .o_link_flag      (o_link_flag),
        .o_device_address (o_device_address),
        .o_command_code   (o_command_code)
    );

endmodule

### hw/rtl/irpfd_classify.sv
module irpfd_classify
    import irpfd_pkg::*;
(
    input  logic [TICK_W-1:0] i_ticks,
    output t_sym              o_sym
);

    always_comb begin
        if (i_ticks >= ZERO_LO && i_ticks <= ZERO_HI) begin
            o_sym = CODE_ZERO;
        end else if (i_ticks >= SAME_LO && i_ticks <= SAME_HI) begin
            o_sym = CODE_SAME;
        end else if (i_ticks >= ONE_LO && i_ticks <= ONE_HI) begin
            o_sym = CODE_ONE;
        end else if (i_ticks >= STOP_LO && i_ticks <= STOP_HI) begin
            o_sym = CODE_STOP;
        end else if (i_ticks >= START_LO && i_ticks <= START_HI) begin
            o_sym = CODE_START;
        end else begin
            o_sym = CODE_BAD;
        end
    end

endmodule

### hw/rtl/irpfd_frame.sv
module irpfd_frame
    import irpfd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_sym_item         i_item,
    input  logic              i_stall,
    output logic              o_advance,
    output logic              o_valid,
    output logic              o_link_flag,
    output logic [BYTE_W-1:0] o_device_address,
    output logic [BYTE_W-1:0] o_command_code
);

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [FRAME_W-1:0] r_shift, n_shift;
    logic               r_last,  n_last;
    logic               r_out_valid;
    logic               r_link;
    logic [BYTE_W-1:0]  r_addr;
    logic [BYTE_W-1:0]  r_cmd;

    logic               emit;
    logic               take;
    logic               data_bit;
    logic [COUNT_W-1:0] count_inc;

    assign emit      = i_item.item_valid && (r_phase == PH_STOP) && (i_item.sym == CODE_STOP);
    // hold the item only when it carries a result and the result slot is still full
    assign o_advance = !emit || !r_out_valid || !i_stall;
    assign take      = i_item.item_valid && o_advance;
    assign count_inc = r_count + COUNT_W'(1);

    always_comb begin
        case (i_item.sym)
            CODE_ONE:  data_bit = 1'b1;
            CODE_SAME: data_bit = r_last;
            default:   data_bit = 1'b0;
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_shift = r_shift;
        n_last  = r_last;
        if (take) begin
            if (i_item.sym == CODE_BAD) begin
                n_phase = PH_IDLE;
                n_count = '0;
                n_shift = '0;
                n_last  = 1'b0;
            end else begin
                case (r_phase)
                    PH_DATA: begin
                        if (i_item.sym == CODE_ZERO || i_item.sym == CODE_ONE ||
                            i_item.sym == CODE_SAME) begin
                            n_shift = {r_shift[FRAME_W-2:0], data_bit};
                            n_last  = data_bit;
                            n_count = count_inc;
                            if (count_inc >= FRAME_BITS) begin
                                n_phase = PH_STOP;
                            end
                        end else begin
                            n_phase = PH_IDLE;
                            n_count = '0;
                            n_shift = '0;
                            n_last  = 1'b0;
                        end
                    end
                    PH_STOP: begin
                        n_phase = PH_IDLE;
                        n_count = '0;
                        n_shift = '0;
                        n_last  = 1'b0;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        if (i_item.sym == CODE_START) begin
                            n_phase = PH_DATA;
                            n_count = '0;
                            n_shift = '0;
                            n_last  = 1'b0;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_count     <= '0;
            r_shift     <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_shift <= n_shift;
            r_last  <= n_last;
            if (take && emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && emit) begin
            r_link <= r_shift[FRAME_W-1];
            r_addr <= r_shift[2*BYTE_W-1:BYTE_W];
            r_cmd  <= r_shift[BYTE_W-1:0];
        end
    end

    assign o_valid          = r_out_valid;
    assign o_link_flag      = r_link;
    assign o_device_address = r_addr;
    assign o_command_code   = r_cmd;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FRAME_BITS)
        else $error("bit count beyond frame length");

    a_stop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_STOP |-> r_count == FRAME_BITS)
        else $error("stop expected before frame is full");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> (r_count == '0 && r_shift == '0 && !r_last))
        else $error("idle with stale frame state");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && emit) |=> (r_out_valid && r_phase == PH_IDLE))
        else $error("completed frame not presented");

    a_no_phase3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != 2'd3)
        else $error("unused phase code reached");

endmodule

### test/tb_ir_pulse_frame_decoder.sv
`timescale 1ns / 100ps

module tb_ir_pulse_frame_decoder;
    import irpfd_pkg::*;

    // One decoded frame as the block should present it
    typedef struct packed {
        logic              link;
        logic [BYTE_W-1:0] address;
        logic [BYTE_W-1:0] command;
    } frame_fields_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [TICK_W-1:0] i_pulse_ticks;
    logic              o_valid;
    logic              i_stall;
    logic              o_link_flag;
    logic [BYTE_W-1:0] o_device_address;
    logic [BYTE_W-1:0] o_command_code;

    ir_pulse_frame_decoder dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_pulse_ticks    (i_pulse_ticks),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_link_flag      (o_link_flag),
        .o_device_address (o_device_address),
        .o_command_code   (o_command_code)
    );

    // Frames decoded by the predictor and not yet seen at the output, oldest first
    frame_fields_t frames_due[$];

    // Predictor copy of the decoder state
    logic [PHASE_W-1:0] rx_phase = PH_IDLE;
    logic [COUNT_W-1:0] rx_count = '0;
    logic [FRAME_W-1:0] rx_shift = '0;
    logic               rx_last  = 1'b0;

    int  mismatches  = 0;
    int  pulses_used = 0;    // intervals that the decoder did not simply ignore
    bit  gaps_on     = 1'b0; // sender inserts idle bursts
    bit  stalls_on   = 1'b0; // receiver inserts stall bursts

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: a correct run ends far sooner than this
    initial begin
        #(10_000_000);
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Map an interval length onto its symbol; everything outside the windows is bad
    function automatic t_sym classify_pulse(input logic [TICK_W-1:0] ticks);
        if (ticks >= ZERO_LO && ticks <= ZERO_HI)   return CODE_ZERO;
        if (ticks >= SAME_LO && ticks <= SAME_HI)   return CODE_SAME;
        if (ticks >= ONE_LO && ticks <= ONE_HI)     return CODE_ONE;
        if (ticks >= STOP_LO && ticks <= STOP_HI)   return CODE_STOP;
        if (ticks >= START_LO && ticks <= START_HI) return CODE_START;
        return CODE_BAD;
    endfunction

    function automatic void drop_frame();
        rx_phase = PH_IDLE;
        rx_count = '0;
        rx_shift = '0;
        rx_last  = 1'b0;
    endfunction

    // Advance the predictor by one accepted interval; queue a frame on a good stop
    function automatic void decode_pulse(input logic [TICK_W-1:0] ticks);
        t_sym sym;
        logic data_bit;
        sym = classify_pulse(ticks);
        if (rx_phase != PH_IDLE || sym == CODE_START)
            pulses_used++;
        if (sym == CODE_BAD) begin
            drop_frame();
            return;
        end
        case (rx_phase)
            PH_DATA: begin
                if (sym == CODE_ZERO || sym == CODE_ONE || sym == CODE_SAME) begin
                    // same-as-previous repeats the last data bit, zero at frame start
                    data_bit = (sym == CODE_ONE) ? 1'b1 : (sym == CODE_SAME) ? rx_last : 1'b0;
                    rx_shift = {rx_shift[FRAME_W-2:0], data_bit};
                    rx_last  = data_bit;
                    rx_count = rx_count + 1'b1;
                    if (rx_count >= FRAME_BITS)
                        rx_phase = PH_STOP;
                end else begin
                    // start or stop inside the data bits aborts the frame
                    drop_frame();
                end
            end
            PH_STOP: begin
                if (sym == CODE_STOP)
                    frames_due.push_back('{rx_shift[FRAME_W-1],
                                           rx_shift[2*BYTE_W-1:BYTE_W],
                                           rx_shift[BYTE_W-1:0]});
                drop_frame();
            end
            default: begin
                // idle: only a start interval opens a frame
                if (sym == CODE_START) begin
                    rx_phase = PH_DATA;
                    rx_count = '0;
                    rx_shift = '0;
                    rx_last  = 1'b0;
                end else begin
                    rx_phase = PH_IDLE;
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Monitor: check results and feed the predictor at each rising edge
    // ------------------------------------------------------------------

    task automatic report_field(input string name, input logic [BYTE_W-1:0] want,
                                input logic [BYTE_W-1:0] seen);
        $display("%0t ERROR %s: expected 0x%h, actual 0x%h", $time, name, want, seen);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        frame_fields_t want;
        if (i_rst_n) begin
            // Compare first, so a frame decoded at this edge is not taken early
            if (o_valid && !i_stall) begin
                if (frames_due.size() == 0) begin
                    $display("%0t ERROR expected no frame, actual link %b address 0x%h command 0x%h",
                             $time, o_link_flag, o_device_address, o_command_code);
                    mismatches++;
                end else begin
                    want = frames_due.pop_front();
                    if (o_link_flag !== want.link)
                        report_field("link_flag", BYTE_W'(want.link), BYTE_W'(o_link_flag));
                    if (o_device_address !== want.address)
                        report_field("device_address", want.address, o_device_address);
                    if (o_command_code !== want.command)
                        report_field("command_code", want.command, o_command_code);
                end
            end
            if (i_valid && !o_stall)
                decode_pulse(i_pulse_ticks);
        end
    end

    // Receiver: stall in random bursts while enabled
    initial begin : rx_stall_gen
        int   hold_left;
        logic stall_next;
        hold_left = 0;
        i_stall   = 1'b0;
        forever begin
            @(negedge i_clk);
            stall_next = 1'b0;
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else if (stalls_on && $urandom_range(0, 5) == 0) begin
                hold_left  = $urandom_range(1, 14) - 1;
                stall_next = 1'b1;
            end
            i_stall <= stall_next;
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Present one interval from a falling edge, hold it until taken, return at the next
    // falling edge with valid still high
    task automatic send_pulse(input logic [TICK_W-1:0] ticks);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_pulse_ticks <= ticks;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Random interval length within the window of a symbol
    function automatic logic [TICK_W-1:0] pick_ticks(input t_sym sym);
        logic [TICK_W-1:0] ticks;
        case (sym)
            CODE_ZERO:  ticks = TICK_W'($urandom_range(ZERO_HI, ZERO_LO));
            CODE_SAME:  ticks = TICK_W'($urandom_range(SAME_HI, SAME_LO));
            CODE_ONE:   ticks = TICK_W'($urandom_range(ONE_HI, ONE_LO));
            CODE_STOP:  ticks = TICK_W'($urandom_range(STOP_HI, STOP_LO));
            CODE_START: ticks = TICK_W'($urandom_range(START_HI, START_LO));
            default: begin
                do
                    ticks = TICK_W'($urandom_range(0, (1 << TICK_W) - 1));
                while (classify_pulse(ticks) != CODE_BAD);
            end
        endcase
        return ticks;
    endfunction

    // Send start, the first nbits data bits (most significant first), then one tail symbol.
    // A repeated bit goes as same-as-previous now and then.
    task automatic send_frame(input logic [FRAME_W-1:0] bits, input int nbits,
                              input t_sym tail);
        logic prev;
        logic data_bit;
        prev = 1'b0;
        send_pulse(pick_ticks(CODE_START));
        for (int i = 0; i < nbits; i++) begin
            data_bit = bits[FRAME_W-1-i];
            if (data_bit == prev && $urandom_range(0, 2) == 0)
                send_pulse(pick_ticks(CODE_SAME));
            else
                send_pulse(pick_ticks(data_bit ? CODE_ONE : CODE_ZERO));
            prev = data_bit;
        end
        send_pulse(pick_ticks(tail));
    endtask

    // Hold off the sender until every decoded frame has come out
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (frames_due.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Idle ignores everything but start, bad lengths and the extremes included
    task automatic test_idle_noise();
        send_pulse('0);
        send_pulse('1);
        send_pulse(TICK_W'(ZERO_LO + 1));
        send_pulse(TICK_W'(ONE_LO + 1));
        send_pulse(TICK_W'(STOP_LO + 1));
        send_pulse(TICK_W'(SAME_LO + 1));
    endtask

    // Window edges: all ones with link set, then all zeros opened by same-as-previous, then one ordinary frame
    task automatic test_window_edges();
        send_pulse(START_LO);
        for (int i = 0; i < FRAME_W; i++) begin
            case (i % 4)
                0: send_pulse(ONE_LO);
                1: send_pulse(SAME_LO);
                2: send_pulse(SAME_HI);
                default: send_pulse(ONE_HI);
            endcase
        end
        send_pulse(STOP_HI);

        send_pulse(START_HI);
        for (int i = 0; i < FRAME_W; i++) begin
            case (i % 4)
                0: send_pulse(TICK_W'(SAME_LO + 1));
                1: send_pulse(ZERO_LO);
                2: send_pulse(SAME_HI);
                default: send_pulse(ZERO_HI);
            endcase
        end
        send_pulse(STOP_LO);
        send_frame(17'h1_5A3C, FRAME_W, CODE_STOP);
    endtask

    // Aborted frames: stop or start among the data bits, a bad length, a wrong
    // symbol where stop belongs; a good frame must still decode afterwards
    task automatic test_broken_frames();
        send_frame('1, 1, CODE_STOP);
        send_pulse(ONE_LO);
        send_frame('0, 1, CODE_START);
        send_pulse(ZERO_LO);
        send_frame(17'h0_AAAA, 3, CODE_BAD);
        send_frame(17'h1_2345, FRAME_W, CODE_ZERO);
        send_frame(17'h0_F0F0, FRAME_W, CODE_START);
        send_frame(17'h1_0001, FRAME_W, CODE_BAD);
        send_frame(17'h1_0001, FRAME_W, CODE_STOP);
    endtask

    // Mostly well-formed frames with random content; the rest broken frames and noise
    task automatic test_random_traffic(input int count, input bit with_idle);
        int target;
        int pick;
        target = pulses_used + count;
        while (pulses_used < target) begin
            // switch idling per frame so that quiet stretches occur too
            gaps_on   = with_idle && $urandom_range(0, 3) != 0;
            stalls_on = with_idle && $urandom_range(0, 3) != 0;
            pick = $urandom_range(0, 9);
            if (pick < 7)
                send_frame(FRAME_W'($urandom()), FRAME_W, CODE_STOP);
            else if (pick == 7)
                send_frame(FRAME_W'($urandom()), $urandom_range(0, FRAME_W),
                           t_sym'($urandom_range(CODE_BAD, CODE_START)));
            else
                repeat ($urandom_range(1, 6))
                    send_pulse(TICK_W'($urandom_range(0, (1 << TICK_W) - 1)));
        end
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
    endtask

    initial begin : stimulus
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_pulse_ticks = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_idle_noise();
        test_window_edges();
        test_broken_frames();
        wait_drained();

        test_random_traffic(1300, 1'b1);
        // pause the sender until the output side has caught up
        wait_drained();
        test_random_traffic(200, 1'b0);
        wait_drained();

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
